// ----- sv/sed_pkg.sv -----
// shared types and codes for the edit distance block
package sed_pkg;

    // width of the reported counts
    localparam int OUT_W = 6;

    // input action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    // control state of the top level
    typedef enum logic
    {
        ST_RUN,
        ST_DRAIN
    } sed_state_t;

    // per-cell control from the top level
    typedef struct packed
    {
        logic restart;
        logic ref_wr;
    } cell_ctl_t;

endpackage

// ----- sv/sed_cell.sv -----
// one cell of the systolic row: holds a reference byte and one row entry
module sed_cell
    import sed_pkg::*;
#(
    parameter int DW  = 6,
    parameter int IDX = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [7:0]    wr_char,
    input  logic          left_valid,
    input  logic [7:0]    left_char,
    input  logic [DW-1:0] left_new,
    input  logic [DW-1:0] left_old,
    output logic          right_valid,
    output logic [7:0]    right_char,
    output logic [DW-1:0] right_new,
    output logic [DW-1:0] right_old
);

    logic [7:0]    ref_char_reg;
    logic [DW-1:0] dist_reg;
    logic [DW-1:0] old_reg;
    logic [7:0]    ch_reg;
    logic          v_reg;

    logic          cost;
    logic [DW:0]   cand_up;
    logic [DW:0]   cand_left;
    logic [DW:0]   cand_diag;
    logic [DW:0]   best;
    logic [DW-1:0] dist_next;

    // reference byte, written by the append that targets this cell
    always_ff @(posedge clk)
    begin
        if (ctl.ref_wr)
        begin
            ref_char_reg <= wr_char;
        end
    end

    // min of delete, insert and substitute
    always_comb
    begin
        cost      = (ref_char_reg != left_char);
        cand_up   = {1'b0, dist_reg} + {{DW{1'b0}}, 1'b1};
        cand_left = {1'b0, left_new} + {{DW{1'b0}}, 1'b1};
        cand_diag = {1'b0, left_old} + {{DW{1'b0}}, cost};
        best      = (cand_up < cand_left) ? cand_up : cand_left;
        if (cand_diag < best)
        begin
            best = cand_diag;
        end
        dist_next = best[DW-1:0];
    end

    // row entry and the wavefront handed to the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DW'(IDX);
            v_reg    <= 1'b0;
        end
        else if (ctl.restart)
        begin
            dist_reg <= DW'(IDX);
            v_reg    <= 1'b0;
        end
        else
        begin
            v_reg <= left_valid;
            if (left_valid)
            begin
                dist_reg <= dist_next;
            end
        end
    end

    // payload of the wavefront
    always_ff @(posedge clk)
    begin
        if (left_valid)
        begin
            old_reg <= dist_reg;
            ch_reg  <= left_char;
        end
    end

    assign right_valid = v_reg;
    assign right_char  = ch_reg;
    assign right_new   = dist_reg;
    assign right_old   = old_reg;

endmodule

// ----- sv/string_similarity_edit_distance.sv -----
// top level: streaming levenshtein distance over a row of systolic cells
//
// usage
//   input channel (in_valid / in_stall) carries one beat per action:
//   clear reference, append reference byte, query byte, end of query.
//   clear, append and query beats are taken one per cycle while the
//   input is not stalled and give no result. query bytes enter a skewed
//   wavefront that walks the row of MAX_LEN cells, one cell per cycle, so
//   a query streams at one byte a cycle. an end-of-query beat stalls the
//   input until the wavefront has left the row and the output register
//   is free. the result beat (similarity, distance, overflow) sits in
//   an output register on the out channel (out_valid / out_stall);
//   while it waits, further clear, append and query beats are still
//   taken. reset empties the reference and the query, clears overflow
//   and drops any result not yet delivered; the reference bytes
//   themselves are undefined until appended.
module string_similarity_edit_distance
    import sed_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [7:0]       char_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OUT_W-1:0] similarity,
    output logic [OUT_W-1:0] distance,
    output logic             overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);

    sed_state_t state_reg;
    sed_state_t state_next;

    logic [LW-1:0] ref_len_reg;
    logic [LW-1:0] qlen_reg;
    logic          ovf_reg;

    logic          s0_v_reg;
    logic [7:0]    s0_ch_reg;
    logic [LW-1:0] s0_new_reg;
    logic [LW-1:0] s0_old_reg;

    logic             out_v_reg;
    logic [OUT_W-1:0] sim_reg;
    logic [OUT_W-1:0] dist_reg;
    logic             ovf_out_reg;

    logic             acc;
    logic             busy;
    logic             out_free;
    logic             finish;
    logic             restart;
    logic [LW-1:0]    sel_dist;
    logic [LW-1:0]    longer;
    logic [LW-1:0]    sim_val;
    logic [LW+OUT_W-1:0] sim_ext;
    logic [LW+OUT_W-1:0] dist_ext;

    logic [MAX_LEN:0] c_v;
    logic [7:0]       c_ch   [0:MAX_LEN];
    logic [LW-1:0]    c_new  [0:MAX_LEN];
    logic [LW-1:0]    c_old  [0:MAX_LEN];
    logic [LW-1:0]    d_row  [0:MAX_LEN];
    cell_ctl_t        c_ctl  [1:MAX_LEN];

    // handshake and drain status
    assign acc      = in_valid && !in_stall;
    assign busy     = |c_v;
    assign out_free = !out_v_reg || !out_stall;
    assign finish   = (state_reg == ST_DRAIN) && !busy && out_free;
    assign restart  = finish
                    || (acc && ((action == ACT_CLEAR) || (action == ACT_APPEND)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (acc && (action == ACT_END))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            ST_RUN:   in_stall = 1'b0;
            ST_DRAIN: in_stall = 1'b1;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // lengths and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg <= '0;
            qlen_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (acc && (action == ACT_CLEAR))
        begin
            ref_len_reg <= '0;
            qlen_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (acc && (action == ACT_APPEND))
        begin
            qlen_reg <= '0;
            if (ref_len_reg == LW'(MAX_LEN))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                ref_len_reg <= ref_len_reg + LW'(1);
            end
        end
        else if (acc && (action == ACT_QUERY))
        begin
            if (qlen_reg == LW'(MAX_LEN))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                qlen_reg <= qlen_reg + LW'(1);
            end
        end
        else if (finish)
        begin
            qlen_reg <= '0;
        end
    end

    // column zero of the row: launches the wavefront
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= acc && (action == ACT_QUERY) && (qlen_reg != LW'(MAX_LEN));
        end
    end

    always_ff @(posedge clk)
    begin
        s0_ch_reg  <= char_byte;
        s0_old_reg <= qlen_reg;
        s0_new_reg <= qlen_reg + LW'(1);
    end

    assign c_v[0]   = s0_v_reg;
    assign c_ch[0]  = s0_ch_reg;
    assign c_new[0] = s0_new_reg;
    assign c_old[0] = s0_old_reg;
    assign d_row[0] = qlen_reg;

    // the row of cells
    for (genvar j = 1; j <= MAX_LEN; j++)
    begin : g_cell
        assign c_ctl[j].restart = restart;
        assign c_ctl[j].ref_wr  = acc && (action == ACT_APPEND)
                                && (ref_len_reg == LW'(j - 1));

        sed_cell #(
            .DW  (LW),
            .IDX (j)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (c_ctl[j]),
            .wr_char     (char_byte),
            .left_valid  (c_v[j-1]),
            .left_char   (c_ch[j-1]),
            .left_new    (c_new[j-1]),
            .left_old    (c_old[j-1]),
            .right_valid (c_v[j]),
            .right_char  (c_ch[j]),
            .right_new   (c_new[j]),
            .right_old   (c_old[j])
        );

        assign d_row[j] = c_new[j];
    end

    // result from the entry at the reference length
    always_comb
    begin
        sel_dist = d_row[ref_len_reg];
        longer   = (qlen_reg > ref_len_reg) ? qlen_reg : ref_len_reg;
        sim_val  = (longer >= sel_dist) ? (longer - sel_dist) : '0;
        sim_ext  = {{OUT_W{1'b0}}, sim_val};
        dist_ext = {{OUT_W{1'b0}}, sel_dist};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_v_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sim_reg     <= sim_ext[OUT_W-1:0];
            dist_reg    <= dist_ext[OUT_W-1:0];
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign similarity = sim_reg;
    assign distance   = dist_reg;
    assign overflow   = ovf_out_reg;

    // a result is only loaded once the row is empty
    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg == ST_DRAIN) && $past(!busy))
        else $error("result loaded while wavefront still in flight");

    // lengths stay within the row
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ref_len_reg <= LW'(MAX_LEN)) && (qlen_reg <= LW'(MAX_LEN)))
        else $error("length counter beyond row size");

    // no new query byte enters while draining
    a_no_launch_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_DRAIN) |-> !s0_v_reg)
        else $error("wavefront launched during drain");

    // a pending result is never overwritten before it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_stall) |=> out_v_reg && $stable(dist_reg))
        else $error("pending result lost");

endmodule

// ----- tb/tb_string_similarity_edit_distance.sv -----
// testbench for the streaming levenshtein edit distance block
`timescale 1ns / 1ps

module tb_string_similarity_edit_distance
    import sed_pkg::*;
;

    localparam int MAX_LEN = 32;
    localparam int N_PLAN = 26;
    localparam int RANDOM_BEATS = 580;

    // one result beat as the block reports it
    typedef struct packed
    {
        logic [OUT_W-1:0] sim;
        logic [OUT_W-1:0] dst;
        logic             ovf;
    } score_t;

    // one row of the directed plan, sent reps times in a row
    typedef struct
    {
        logic [1:0] act;
        logic [7:0] ch;
        int         reps;
        bit         typed;
        score_t     want;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       action = ACT_CLEAR;
    logic [7:0]       char_byte = 8'h00;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [OUT_W-1:0] similarity;
    logic [OUT_W-1:0] distance;
    logic             overflow;

    // mirror of the block state
    logic [7:0]       ref_bytes [MAX_LEN];
    logic [5:0]       ref_len;
    logic [5:0]       qry_len;
    logic [5:0]       dist_row [MAX_LEN + 1];
    logic             ovf_flag;

    score_t           pending_scores [$];
    plan_row_t        plan [N_PLAN];
    int               errors = 0;
    int               beats_sent = 0;
    int               out_hold = 0;
    bit               in_burst = 1'b0;
    bit               out_burst = 1'b0;

    string_similarity_edit_distance #(.MAX_LEN(MAX_LEN)) uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .distance   (distance),
        .overflow   (overflow)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #5_000_000;
        $display("tb_string_similarity_edit_distance: FAIL");
        $finish;
    end

    // row back to its initial contents, query emptied
    function automatic void restart_row();
        for (int j = 0; j <= MAX_LEN; j++)
            dist_row[j] = 6'(j);
        qry_len = '0;
    endfunction

    // advance the mirror by one beat; returns 1 when a result is due
    function automatic bit levenshtein_step(input logic [1:0] act, input logic [7:0] ch,
                                            output score_t res);
        logic [5:0] diag;
        logic [5:0] above;
        logic [5:0] best;
        logic [5:0] subst;
        logic [5:0] longer;
        res = '0;
        case (act)
            ACT_CLEAR:
            begin
                ref_len = '0;
                ovf_flag = 1'b0;
                restart_row();
                return 1'b0;
            end
            ACT_APPEND:
            begin
                if (ref_len < MAX_LEN)
                begin
                    ref_bytes[ref_len] = ch;
                    ref_len = ref_len + 6'd1;
                end
                else
                    ovf_flag = 1'b1;
                restart_row();
                return 1'b0;
            end
            ACT_QUERY:
            begin
                if (qry_len >= MAX_LEN)
                    ovf_flag = 1'b1;
                else
                begin
                    diag = dist_row[0];
                    dist_row[0] = qry_len + 6'd1;
                    for (int j = 1; j <= ref_len; j++)
                    begin
                        above = dist_row[j];
                        best = (above < dist_row[j-1]) ? above + 6'd1 : dist_row[j-1] + 6'd1;
                        subst = diag + ((ref_bytes[j-1] == ch) ? 6'd0 : 6'd1);
                        if (subst < best)
                            best = subst;
                        diag = above;
                        dist_row[j] = best;
                    end
                    qry_len = qry_len + 6'd1;
                end
                return 1'b0;
            end
            default:
            begin
                longer = (qry_len > ref_len) ? qry_len : ref_len;
                res.dst = dist_row[ref_len];
                res.sim = (longer >= res.dst) ? longer - res.dst : 6'd0;
                res.ovf = ovf_flag;
                restart_row();
                return 1'b1;
            end
        endcase
    endfunction

    // byte from a narrow alphabet most of the time, so strings share characters
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    // drive one input beat after a random gap and wait until it is taken
    task automatic send_beat(input logic [1:0] act, input logic [7:0] ch);
        int gap;
        score_t res;
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        char_byte <= ch;
        do
            @(posedge clk);
        while (in_stall);
        if (levenshtein_step(act, ch, res))
            pending_scores.push_back(res);
        beats_sent++;
    endtask

    // hold the sender off until every pending result is delivered
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // result side: compare each taken beat, then choose the next stall
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scores.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: sim=%0d dist=%0d ovf=%0b",
                             similarity, distance, overflow);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (similarity !== want.sim || distance !== want.dst
                    || overflow !== want.ovf)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result mismatch: exp sim=%0d dist=%0d ovf=%0b, got sim=%0d dist=%0d ovf=%0b",
                                 want.sim, want.dst, want.ovf,
                                 similarity, distance, overflow);
                end
            end
            if ($urandom_range(0, 19) == 0)
                out_burst = !out_burst;
            out_hold = out_burst ? 0 : $urandom_range(0, 12);
        end
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    // stimulus
    initial
    begin
        int nq;
        int len;
        logic [7:0] ch;

        ref_len = '0;
        ovf_flag = 1'b0;
        restart_row();

        // directed plan: typed results where obvious, mirror elsewhere
        plan = '{
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd0,  1'b0}},  // both strings empty
            '{ACT_QUERY,  8'h00, 1,  1'b0, '0},
            '{ACT_END,    8'hFF, 1,  1'b1, '{6'd0,  6'd1,  1'b0}},  // empty reference
            '{ACT_APPEND, 8'h00, 1,  1'b0, '0},
            '{ACT_APPEND, 8'hFF, 1,  1'b0, '0},
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd2,  1'b0}},  // empty query
            '{ACT_QUERY,  8'h00, 1,  1'b0, '0},
            '{ACT_QUERY,  8'hFF, 1,  1'b0, '0},
            '{ACT_END,    8'h00, 1,  1'b0, '0},
            '{ACT_QUERY,  8'hFF, 1,  1'b0, '0},
            '{ACT_QUERY,  8'h00, 1,  1'b0, '0},
            '{ACT_END,    8'h55, 1,  1'b0, '0},
            '{ACT_QUERY,  8'h80, 1,  1'b0, '0},
            '{ACT_APPEND, 8'h80, 1,  1'b0, '0},                     // append abandons query
            '{ACT_END,    8'hAA, 1,  1'b0, '0},
            '{ACT_CLEAR,  8'hA5, 1,  1'b0, '0},
            '{ACT_APPEND, 8'h5A, 33, 1'b0, '0},                     // reference overfills
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd32, 1'b1}},
            '{ACT_QUERY,  8'h5A, 32, 1'b0, '0},
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd32, 6'd0,  1'b1}},  // full match
            '{ACT_CLEAR,  8'h00, 1,  1'b0, '0},
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd0,  1'b0}},  // clear drops overflow
            '{ACT_QUERY,  8'h7E, 33, 1'b0, '0},                     // query overfills
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd32, 1'b1}},
            '{ACT_END,    8'h00, 1,  1'b1, '{6'd0,  6'd0,  1'b1}},  // overflow is sticky
            '{ACT_CLEAR,  8'hFF, 1,  1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            repeat (plan[i].reps)
                send_beat(plan[i].act, plan[i].ch);
            if (plan[i].typed)
                pending_scores[pending_scores.size() - 1] = plan[i].want;
        end
        drain_results();

        // random part: mostly well-formed reference and query sessions
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any action, any byte
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom), 8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 2) != 0)
                    send_beat(ACT_CLEAR, 8'($urandom));
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 35)
                                                    : $urandom_range(0, 8);
                repeat (len)
                    send_beat(ACT_APPEND, pick_byte());
                nq = $urandom_range(1, 4);
                repeat (nq)
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 35)
                                                        : $urandom_range(0, 9);
                    for (int i = 0; i < len; i++)
                    begin
                        // often follow the reference, sometimes stray from it
                        if (i < ref_len && $urandom_range(0, 2) != 0)
                            ch = ref_bytes[i];
                        else
                            ch = pick_byte();
                        send_beat(ACT_QUERY, ch);
                    end
                    // broken session: reference byte lands in mid query
                    if ($urandom_range(0, 11) == 0)
                        send_beat(ACT_APPEND, pick_byte());
                    if ($urandom_range(0, 15) != 0)
                        send_beat(ACT_END, 8'($urandom));
                end
            end
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end
        in_valid <= 1'b0;

        // wait for the last results, then watch for strays
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (MAX_LEN + 8) @(posedge clk);

        if (errors == 0)
            $display("tb_string_similarity_edit_distance: PASS");
        else
            $display("tb_string_similarity_edit_distance: FAIL");
        $finish;
    end

endmodule
